/* hw/rtl/oflt_pkg.sv */
// Package: character codes, line mode and number phase codes for the OBJ face triangulator.
`timescale 1ns / 1ps

package oflt_pkg;

    // Default width of a vertex index magnitude
    localparam int INDEX_BITS_DEFAULT = 20;

    // Characters of interest
    localparam logic [7:0] CHAR_V     = 8'h76;  // 'v'
    localparam logic [7:0] CHAR_F     = 8'h66;  // 'f'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '
    localparam logic [7:0] CHAR_NL    = 8'h0A;  // newline
    localparam logic [7:0] CHAR_TAB   = 8'h09;  // first of tab, LF, VT, FF, CR
    localparam logic [7:0] CHAR_CR    = 8'h0D;  // last of that range
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_0     = 8'h30;  // '0'
    localparam logic [7:0] CHAR_9     = 8'h39;  // '9'

    // Line mode codes
    localparam logic [2:0] MODE_LINE     = 3'd0;
    localparam logic [2:0] MODE_VSEEN    = 3'd1;
    localparam logic [2:0] MODE_VERTEX   = 3'd2;
    localparam logic [2:0] MODE_SKIP     = 3'd3;
    localparam logic [2:0] MODE_FACE     = 3'd4;
    localparam logic [2:0] MODE_FACE_GAP = 3'd5;

    // Number decoder phases
    localparam logic [1:0] PHASE_LEAD   = 2'd0;
    localparam logic [1:0] PHASE_DIGITS = 2'd1;
    localparam logic [1:0] PHASE_DONE   = 2'd2;

endpackage

/* hw/rtl/obj_face_line_triangulator.sv */
// Top level: OBJ text byte stream in, fan-triangulated face corner indices out.
`timescale 1ns / 1ps

// Channel   Dir  Beat contents
// s_axis    in   tdata[7:0] = text_byte
// m_axis    out  tdata = corner_a, corner_b, corner_c (low to high); tlast = last_of_run
//
// One text byte is taken every cycle while s_axis_tready is high; the line parser updates its
// registers in a single pass. A face line ending in three tokens gives one output beat, four or
// more give two beats. Finished faces wait in a two-entry queue; s_axis_tready drops only while
// both entries are occupied. Synchronous active-low reset clears the control state; the stored
// token indices are not reset and need no clearing pass.

module obj_face_line_triangulator #(
    parameter int INDEX_BITS = oflt_pkg::INDEX_BITS_DEFAULT,
    localparam int CW        = INDEX_BITS + 2,
    localparam int TDATA_W   = ((3 * CW + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] text_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // corner_a, corner_b, corner_c, zero pad
    output logic               m_axis_tlast
);

    localparam int VW = INDEX_BITS + 1;       // magnitude / kept index width
    localparam int PW = INDEX_BITS + 5;       // width of magnitude * 10 + digit
    localparam logic [PW-1:0] LIMIT_W = PW'(1) << INDEX_BITS;
    localparam logic [VW-1:0] MAX_POS = (VW'(1) << INDEX_BITS) - VW'(1);

    typedef struct packed {
        logic          two;
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        logic [CW-1:0] c;
        logic [CW-1:0] d;
    } face_rec_t;

    // Parser state
    logic [2:0]    mode_reg,     mode_next;
    logic          tstart_reg,   tstart_next;
    logic          slash_reg,    slash_next;
    logic          nonempty_reg, nonempty_next;
    logic [VW-1:0] val_reg,      val_next;
    logic [1:0]    phase_reg,    phase_next;
    logic          neg_reg,      neg_next;
    logic [2:0]    tcount_reg,   tcount_next;
    logic [VW-1:0] kept_reg [4];
    logic [VW-1:0] kept_next [4];

    // Output queue
    face_rec_t     rec_reg [2];
    face_rec_t     rec_new;
    logic [1:0]    qcount_reg;
    logic          second_reg;

    logic [7:0]    ch;
    logic          in_beat;
    logic          emit;
    logic          feed_en;
    logic          keep_en;
    logic [VW-1:0] keep_val;
    logic [VW-1:0] tok_val;
    logic [PW-1:0] prod;
    logic          out_beat;
    logic          pop;
    logic          push;

    assign ch       = s_axis_tdata;
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (qcount_reg != 2'd2);

    // Saturated value of the current token
    assign tok_val = neg_reg ? (VW'(0) - val_reg) : (val_reg[INDEX_BITS] ? MAX_POS : val_reg);

    // Decimal accumulate: value * 10 + digit
    assign prod = (PW'(val_reg) << 3) + (PW'(val_reg) << 1) + PW'(ch - oflt_pkg::CHAR_0);

    // Line parser next state
    always_comb begin
        mode_next     = mode_reg;
        tstart_next   = tstart_reg;
        slash_next    = slash_reg;
        nonempty_next = nonempty_reg;
        val_next      = val_reg;
        phase_next    = phase_reg;
        neg_next      = neg_reg;
        tcount_next   = tcount_reg;
        for (int i = 0; i < 4; i++) kept_next[i] = kept_reg[i];
        emit     = 1'b0;
        feed_en  = 1'b0;
        keep_en  = 1'b0;
        keep_val = tok_val;

        case (mode_reg)
            oflt_pkg::MODE_VSEEN: begin
                mode_next = (ch == oflt_pkg::CHAR_SPACE) ? oflt_pkg::MODE_VERTEX
                                                         : oflt_pkg::MODE_LINE;
            end
            oflt_pkg::MODE_VERTEX, oflt_pkg::MODE_SKIP: begin
                if (ch == oflt_pkg::CHAR_NL) mode_next = oflt_pkg::MODE_LINE;
            end
            oflt_pkg::MODE_FACE_GAP, oflt_pkg::MODE_FACE: begin
                if (ch == oflt_pkg::CHAR_NL) begin
                    // end of line: only a face proper closes a token and emits
                    if (mode_reg == oflt_pkg::MODE_FACE) begin
                        keep_en = nonempty_reg && (tok_val != '0);
                        emit    = 1'b1;
                    end
                    mode_next = oflt_pkg::MODE_LINE;
                end else if (ch == oflt_pkg::CHAR_SPACE &&
                             (mode_reg == oflt_pkg::MODE_FACE_GAP || tstart_reg)) begin
                    slash_next = 1'b0;
                    mode_next  = oflt_pkg::MODE_FACE_GAP;
                end else begin
                    // token body
                    mode_next   = oflt_pkg::MODE_FACE;
                    tstart_next = 1'b0;
                    if (ch == oflt_pkg::CHAR_SPACE && nonempty_reg) begin
                        keep_en       = 1'b1;
                        slash_next    = 1'b0;
                        nonempty_next = 1'b0;
                        val_next      = '0;
                        phase_next    = oflt_pkg::PHASE_LEAD;
                        neg_next      = 1'b0;
                        tstart_next   = 1'b1;
                    end else if (ch == oflt_pkg::CHAR_SLASH) begin
                        slash_next = 1'b1;
                    end else if (!slash_next && ch != oflt_pkg::CHAR_SPACE) begin
                        nonempty_next = 1'b1;
                        feed_en       = 1'b1;
                    end
                end
            end
            default: begin
                if (ch == oflt_pkg::CHAR_V) begin
                    mode_next = oflt_pkg::MODE_VSEEN;
                end else if (ch == oflt_pkg::CHAR_F) begin
                    mode_next     = oflt_pkg::MODE_FACE;
                    tstart_next   = 1'b1;
                    slash_next    = 1'b0;
                    nonempty_next = 1'b0;
                    val_next      = '0;
                    phase_next    = oflt_pkg::PHASE_LEAD;
                    neg_next      = 1'b0;
                    tcount_next   = '0;
                end else if (ch == oflt_pkg::CHAR_NL) begin
                    mode_next = oflt_pkg::MODE_LINE;
                end else begin
                    mode_next = oflt_pkg::MODE_SKIP;
                end
            end
        endcase

        // number decoder (atoi-like)
        if (feed_en) begin
            if (phase_reg == oflt_pkg::PHASE_LEAD &&
                (ch == oflt_pkg::CHAR_SPACE ||
                 ch inside {[oflt_pkg::CHAR_TAB:oflt_pkg::CHAR_CR]})) begin
                phase_next = phase_reg;
            end else if (phase_reg == oflt_pkg::PHASE_LEAD && ch == oflt_pkg::CHAR_PLUS) begin
                phase_next = oflt_pkg::PHASE_DIGITS;
            end else if (phase_reg == oflt_pkg::PHASE_LEAD && ch == oflt_pkg::CHAR_MINUS) begin
                neg_next   = 1'b1;
                phase_next = oflt_pkg::PHASE_DIGITS;
            end else if (phase_reg == oflt_pkg::PHASE_LEAD ||
                         phase_reg == oflt_pkg::PHASE_DIGITS) begin
                if (ch inside {[oflt_pkg::CHAR_0:oflt_pkg::CHAR_9]}) begin
                    val_next   = (prod > LIMIT_W) ? VW'(LIMIT_W) : VW'(prod);
                    phase_next = oflt_pkg::PHASE_DIGITS;
                end else begin
                    phase_next = oflt_pkg::PHASE_DONE;
                end
            end
        end

        // store a finished token, up to four
        if (keep_en && tcount_reg < 3'd4) begin
            kept_next[tcount_reg[1:0]] = keep_val;
            tcount_next                = tcount_reg + 3'd1;
        end
    end

    // Face record from the indices as they stand after this byte
    always_comb begin
        rec_new.two = (tcount_next >= 3'd4);
        rec_new.a   = {kept_next[0][VW-1], kept_next[0]} - CW'(1);
        rec_new.b   = {kept_next[1][VW-1], kept_next[1]} - CW'(1);
        rec_new.c   = {kept_next[2][VW-1], kept_next[2]} - CW'(1);
        rec_new.d   = {kept_next[3][VW-1], kept_next[3]} - CW'(1);
    end

    assign push = in_beat && emit && (tcount_next >= 3'd3);

    // Parser registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= oflt_pkg::MODE_LINE;
            tstart_reg   <= 1'b1;
            slash_reg    <= 1'b0;
            nonempty_reg <= 1'b0;
            val_reg      <= '0;
            phase_reg    <= oflt_pkg::PHASE_LEAD;
            neg_reg      <= 1'b0;
            tcount_reg   <= '0;
        end else if (in_beat) begin
            mode_reg     <= mode_next;
            tstart_reg   <= tstart_next;
            slash_reg    <= slash_next;
            nonempty_reg <= nonempty_next;
            val_reg      <= val_next;
            phase_reg    <= phase_next;
            neg_reg      <= neg_next;
            tcount_reg   <= tcount_next;
        end
    end

    // Kept indices, no reset
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            for (int i = 0; i < 4; i++) kept_reg[i] <= kept_next[i];
        end
    end

    // Output side: head record gives one or two beats
    assign m_axis_tvalid = (qcount_reg != 2'd0);
    assign out_beat      = m_axis_tvalid && m_axis_tready;
    assign m_axis_tlast  = second_reg || !rec_reg[0].two;
    assign pop           = out_beat && m_axis_tlast;
    assign m_axis_tdata  = TDATA_W'({(second_reg ? rec_reg[0].d : rec_reg[0].c),
                                     (second_reg ? rec_reg[0].c : rec_reg[0].b),
                                     rec_reg[0].a});

    // Queue control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qcount_reg <= '0;
            second_reg <= 1'b0;
        end else begin
            if (push && !pop)      qcount_reg <= qcount_reg + 2'd1;
            else if (pop && !push) qcount_reg <= qcount_reg - 2'd1;
            if (pop)           second_reg <= 1'b0;
            else if (out_beat) second_reg <= 1'b1;
        end
    end

    // Queue payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            rec_reg[0] <= (push && qcount_reg == 2'd1) ? rec_new : rec_reg[1];
            if (push) rec_reg[1] <= rec_new;
        end else if (push) begin
            if (qcount_reg == 2'd0) rec_reg[0] <= rec_new;
            else                    rec_reg[1] <= rec_new;
        end
    end

endmodule

/* test/tb_top.sv */
// Testbench for the OBJ face-line triangulator: directed text lines, then random OBJ text.
`timescale 1ns / 1ps

module tb_top;
    import oflt_pkg::*;

    localparam int IDX_W        = INDEX_BITS_DEFAULT;
    localparam int CW           = IDX_W + 2;
    localparam int TDATA_W      = ((3 * CW + 7) / 8) * 8;
    localparam int MAG_CAP      = 1 << IDX_W;
    localparam int TEXT_BYTES   = 870;     // random part; the directed table adds about 180
    localparam int MAX_GAP      = 18;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int N_ROWS       = 16;
    localparam int PREDICTED    = -1;

    typedef logic signed [CW-1:0] corner_t;
    typedef struct packed {
        corner_t corner_a;
        corner_t corner_b;
        corner_t corner_c;
        logic    last_of_run;
    } tri_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;   // [7:0] text_byte
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;         // corner_a, corner_b, corner_c, zero pad
    logic               m_axis_tlast;         // last_of_run

    tri_t       tri_expected[$];
    logic [7:0] line_q[$];
    int         mismatches  = 0;
    int         cycle_count = 0;
    int         tx_calm     = 0;
    int         rx_calm     = 0;

    // Clock, 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    obj_face_line_triangulator #(
        .INDEX_BITS(IDX_W)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Directed lines; typed expectations where the answer is obvious
    string row_text [N_ROWS] = '{
        "f 1 2 3\n",
        "f 1 2 3 4\n",
        "\n",
        "v 1.5 -2 3\n",
        "vf 1 2 3\n",                       // byte after 'v' swallowed, then skipped
        "vxf 2 3 4\n",                      // byte after 'v' swallowed, face follows
        "f 7/8/9 10//2 -3/1 99999999\n",    // slashes, negative, positive saturation
        "f -99999999 0 2 0\n",              // negative saturation, trailing zero dropped
        "f 1 2 3  \n",                      // two spaces before newline abort the line
        "f 1 2 3 \n",                       // single trailing space is harmless
        "f +5 \t6 x7 8 9 10\n",             // sign, leading tab, non-digit, extra tokens
        "f 1 2\n",
        "# f 1 2 3\n",
        "f  1  2 3\n",
        "f 1 2 0\n",
        "f 1/2 3/ /4 5 6\n"                 // token starting with a slash swallows the rest
    };
    int row_tris [N_ROWS] = '{1, 2, 0, 0, 0, 1, PREDICTED, PREDICTED, 0, 1, PREDICTED, 0, 0,
                              PREDICTED, 0, PREDICTED};
    int row_corners [N_ROWS][6] = '{
        '{0, 1, 2, 0, 0, 0}, '{0, 1, 2, 0, 2, 3}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0}, '{1, 2, 3, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0}, '{0, 1, 2, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}
    };

    // Parser state of the predictor, at reset values
    logic [2:0] pr_mode      = MODE_LINE;
    bit         pr_tok_start = 1'b1;
    bit         pr_slash     = 1'b0;
    bit         pr_nonempty  = 1'b0;
    bit         pr_neg       = 1'b0;
    logic [1:0] pr_phase     = PHASE_LEAD;
    int         pr_mag       = 0;
    int         pr_count     = 0;
    int         pr_kept [4]  = '{0, 0, 0, 0};

    function automatic tri_t make_tri(input int a, input int b, input int c, input logic last);
        tri_t t;
        t.corner_a    = corner_t'(a);
        t.corner_b    = corner_t'(b);
        t.corner_c    = corner_t'(c);
        t.last_of_run = last;
        return t;
    endfunction

    task automatic clear_token_state();
        pr_slash    = 1'b0;
        pr_nonempty = 1'b0;
        pr_mag      = 0;
        pr_phase    = PHASE_LEAD;
        pr_neg      = 1'b0;
    endtask

    function automatic int token_value();
        if (pr_neg)
            return -pr_mag;
        return (pr_mag > MAG_CAP - 1) ? MAG_CAP - 1 : pr_mag;
    endfunction

    task automatic store_token(input int v);
        if (pr_count < 4) begin
            pr_kept[pr_count] = v;
            pr_count++;
        end
    endtask

    // atoi-style decoding with a saturating magnitude
    task automatic decode_char(input logic [7:0] c);
        if (pr_phase == PHASE_LEAD) begin
            if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
                return;
            if (c == CHAR_PLUS) begin
                pr_phase = PHASE_DIGITS;
                return;
            end
            if (c == CHAR_MINUS) begin
                pr_neg   = 1'b1;
                pr_phase = PHASE_DIGITS;
                return;
            end
        end
        if (pr_phase != PHASE_DONE) begin
            if (c >= CHAR_0 && c <= CHAR_9) begin
                pr_mag = pr_mag * 10 + int'(c - CHAR_0);
                if (pr_mag > MAG_CAP)
                    pr_mag = MAG_CAP;
                pr_phase = PHASE_DIGITS;
            end else begin
                pr_phase = PHASE_DONE;
            end
        end
    endtask

    task automatic face_char(input logic [7:0] c);
        if (c == CHAR_SPACE && pr_nonempty) begin
            store_token(token_value());
            clear_token_state();
            pr_tok_start = 1'b1;
        end else if (c == CHAR_SLASH) begin
            pr_slash = 1'b1;
        end else if (!pr_slash && c != CHAR_SPACE) begin
            pr_nonempty = 1'b1;
            decode_char(c);
        end
    endtask

    // One text byte through the predictor; triangles are queued when keep is set
    task automatic triangulate_byte(input logic [7:0] c, input bit keep);
        case (pr_mode)
            MODE_VSEEN: begin
                pr_mode = (c == CHAR_SPACE) ? MODE_VERTEX : MODE_LINE;
            end
            MODE_VERTEX, MODE_SKIP: begin
                if (c == CHAR_NL)
                    pr_mode = MODE_LINE;
            end
            MODE_FACE_GAP: begin
                if (c == CHAR_NL) begin
                    pr_mode = MODE_LINE;
                end else if (c == CHAR_SPACE) begin
                    pr_slash = 1'b0;
                end else begin
                    pr_mode      = MODE_FACE;
                    pr_tok_start = 1'b0;
                    face_char(c);
                end
            end
            MODE_FACE: begin
                if (c == CHAR_NL) begin
                    if (pr_nonempty && token_value() != 0)
                        store_token(token_value());
                    if (keep) begin
                        if (pr_count == 3) begin
                            tri_expected.push_back(make_tri(pr_kept[0] - 1, pr_kept[1] - 1,
                                                            pr_kept[2] - 1, 1'b1));
                        end else if (pr_count >= 4) begin
                            tri_expected.push_back(make_tri(pr_kept[0] - 1, pr_kept[1] - 1,
                                                            pr_kept[2] - 1, 1'b0));
                            tri_expected.push_back(make_tri(pr_kept[0] - 1, pr_kept[2] - 1,
                                                            pr_kept[3] - 1, 1'b1));
                        end
                    end
                    pr_mode = MODE_LINE;
                end else if (pr_tok_start && c == CHAR_SPACE) begin
                    pr_slash = 1'b0;
                    pr_mode  = MODE_FACE_GAP;
                end else begin
                    pr_tok_start = 1'b0;
                    face_char(c);
                end
            end
            default: begin
                if (c == CHAR_V) begin
                    pr_mode = MODE_VSEEN;
                end else if (c == CHAR_F) begin
                    pr_mode      = MODE_FACE;
                    pr_tok_start = 1'b1;
                    clear_token_state();
                    pr_count     = 0;
                end else if (c == CHAR_NL) begin
                    pr_mode = MODE_LINE;
                end else begin
                    pr_mode = MODE_SKIP;
                end
            end
        endcase
    endtask

    // Idle cycles before a beat; calm stretches give back-to-back beats
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm = $urandom_range(8, 48);
        return $urandom_range(0, MAX_GAP);
    endfunction

    task automatic log_mismatch(input string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task automatic send_text_byte(input logic [7:0] ch, input bit keep);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        do @(posedge aclk); while (!s_axis_tready);
        triangulate_byte(ch, keep);
    endtask

    task automatic add_digits(input int n);
        for (int i = 0; i < n; i++)
            line_q.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
    endtask

    // Random face line: mostly three or four tokens, with the odd wrinkle
    task automatic build_face_line();
        int         ntok;
        int         ws;
        logic [7:0] stray;
        line_q.push_back(CHAR_F);
        ntok = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : $urandom_range(3, 4);
        for (int t = 0; t < ntok; t++) begin
            line_q.push_back(CHAR_SPACE);
            if ($urandom_range(0, 7) == 0)
                line_q.push_back(CHAR_SPACE);
            if ($urandom_range(0, 9) == 0) begin
                ws = $urandom_range(0, 3);
                line_q.push_back((ws == 1) ? CHAR_CR : CHAR_TAB + 8'(ws));
            end
            if ($urandom_range(0, 9) == 0)
                line_q.push_back($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
            add_digits(($urandom_range(0, 15) == 0) ? $urandom_range(6, 9)
                                                     : $urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0) begin
                line_q.push_back(CHAR_SLASH);
                add_digits($urandom_range(0, 2));
                if ($urandom_range(0, 1)) begin
                    line_q.push_back(CHAR_SLASH);
                    add_digits($urandom_range(1, 2));
                end
            end
            if ($urandom_range(0, 19) == 0) begin
                stray = 8'($urandom_range(0, 255));
                line_q.push_back((stray == CHAR_NL) ? CHAR_SLASH : stray);
            end
        end
        case ($urandom_range(0, 9))
            0: begin
                line_q.push_back(CHAR_SPACE);
                line_q.push_back(CHAR_SPACE);
            end
            1: line_q.push_back(CHAR_SPACE);
            default: ;
        endcase
        line_q.push_back(CHAR_NL);
    endtask

    // Cycle watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stalls, each beat checked against the oldest expectation
    initial begin : triangle_sink
        int      gap;
        tri_t    want;
        corner_t got_a;
        corner_t got_b;
        corner_t got_c;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap(rx_calm);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            got_a = m_axis_tdata[CW-1:0];
            got_b = m_axis_tdata[2*CW-1:CW];
            got_c = m_axis_tdata[3*CW-1:2*CW];
            if (tri_expected.size() == 0) begin
                log_mismatch($sformatf("unexpected beat a=%0d b=%0d c=%0d last=%0b",
                                       got_a, got_b, got_c, m_axis_tlast));
            end else begin
                want = tri_expected.pop_front();
                if (got_a !== want.corner_a)
                    log_mismatch($sformatf("corner_a got %0d want %0d", got_a, want.corner_a));
                if (got_b !== want.corner_b)
                    log_mismatch($sformatf("corner_b got %0d want %0d", got_b, want.corner_b));
                if (got_c !== want.corner_c)
                    log_mismatch($sformatf("corner_c got %0d want %0d", got_c, want.corner_c));
                if (m_axis_tlast !== want.last_of_run)
                    log_mismatch($sformatf("last_of_run got %0b want %0b",
                                           m_axis_tlast, want.last_of_run));
            end
        end
    end

    // Text side: reset, directed lines, random lines, drain
    initial begin : text_source
        int kind;
        int pos;
        int n;
        int text_bytes;
        text_bytes = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table
        for (int r = 0; r < N_ROWS; r++) begin
            for (int i = 0; i < row_text[r].len(); i++)
                send_text_byte(row_text[r][i], row_tris[r] == PREDICTED);
            if (row_tris[r] >= 1)
                tri_expected.push_back(make_tri(row_corners[r][0], row_corners[r][1],
                                                row_corners[r][2], row_tris[r] == 1));
            if (row_tris[r] == 2)
                tri_expected.push_back(make_tri(row_corners[r][3], row_corners[r][4],
                                                row_corners[r][5], 1'b1));
        end

        // Random text: mostly face lines, some vertex lines, noise and broken lines
        while (text_bytes < TEXT_BYTES) begin
            line_q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                build_face_line();
                // corrupt one byte now and then, newline included
                if (kind >= 60) begin
                    pos = $urandom_range(0, line_q.size() - 1);
                    line_q[pos] = 8'($urandom_range(0, 255));
                end
            end else if (kind < 80) begin
                line_q.push_back(CHAR_V);
                line_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                             : CHAR_SPACE);
                n = $urandom_range(0, 10);
                for (int i = 0; i < n; i++)
                    line_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
                line_q.push_back(CHAR_NL);
            end else begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    line_q.push_back(8'($urandom_range(0, 255)));
                line_q.push_back(CHAR_NL);
            end
            foreach (line_q[i])
                send_text_byte(line_q[i], 1'b1);
            text_bytes += line_q.size();
        end
        s_axis_tvalid <= 1'b0;

        // Wait for outstanding triangles, then a short tail for stray beats
        while (tri_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
